// ----- sv/accel_vi_pkg.sv -----
// -----------------------------------------------------------------------------
// Velocity integrator package
// Field widths, register indexes, reset values and serial datapath sizes
// shared by the velocity integrator core and its checker.
// -----------------------------------------------------------------------------
package accel_vi_pkg;

  // Stream fields
  localparam int unsigned ACC_W   = 16;  // raw accelerometer sample
  localparam int unsigned TS_W    = 32;  // millisecond timestamp
  localparam int unsigned VEL_W   = 32;  // velocity, signed Q15.16
  localparam int unsigned IN_W    = 48;  // raw_accel + timestamp_ms
  localparam int unsigned OUT_W   = 32;  // velocity_q16

  // Configuration port
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_DB = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_DB   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 2'd2;

  localparam logic [CFG_W-1:0] ACCEL_DB_RST = 16'd13107;  // 0.2 m/s^2
  localparam logic [CFG_W-1:0] VEL_DB_RST   = 16'd655;    // 0.01 m/s
  localparam logic [CFG_W-1:0] DECAY_RST    = 16'd64225;  // 0.98

  localparam int unsigned CAL_SAMPLES_DEF = 500;

  // Calibration and offset
  localparam int unsigned SUM_W    = 25;  // signed offset sum
  localparam int unsigned OFS_W    = 25;  // signed Q15.9 offset
  localparam int unsigned OFS_FRAC = 9;
  localparam int unsigned DIFF_W   = 26;  // raw * 2^9 - offset

  // Shift-add multiplier: 32-bit multiplicand, 23-bit multiplier
  localparam int unsigned MA_W    = 32;
  localparam int unsigned ML_W    = 23;
  localparam int unsigned PROD_W  = MA_W + ML_W;
  localparam int unsigned G_SHIFT = 23;  // gravity scale is 2^23
  localparam int unsigned D_SHIFT = 16;  // decay scale is 2^16
  localparam logic [ML_W-1:0] GRAVITY_Q16 = 23'd642908;  // 9.81 * 2^16

  // Restoring divider, one quotient bit per cycle
  localparam int unsigned DQ_W  = PROD_W;
  localparam int unsigned DEN_W = 10;
  localparam logic [DEN_W-1:0] DT_DIV  = 10'd1000;
  localparam logic [DEN_W-1:0] DT_HALF = 10'd500;

  // Velocity update
  localparam int unsigned QC_W   = 34;  // clamped velocity increment
  localparam int unsigned VSUM_W = 35;
  localparam logic [QC_W-1:0]  QC_LIMIT = {1'b1, {(QC_W-1){1'b0}}};
  localparam logic [VEL_W-1:0] VEL_MAX  = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN  = {1'b1, {(VEL_W-1){1'b0}}};

  // Step counter
  localparam int unsigned STEP_W = 6;
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(ML_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DQ_W - 1);

endpackage

// ----- sv/accel_velocity_integrator_core.sv -----
// -----------------------------------------------------------------------------
// Accelerometer velocity integrator core
// Leaky velocity integrator with acceleration and velocity deadbands, offset
// calibration, and a bit-serial multiply/divide datapath.
// -----------------------------------------------------------------------------
//  channel   direction  handshake                 payload (low bit first)
//  s_axis    in         s_axis_tvalid/tready      tdata: raw_accel[15:0],
//                                                 timestamp_ms[31:0]
//                                                 tuser: req_type
//  m_axis    out        m_axis_tvalid/tready      tdata: velocity_q16[31:0]
//                                                 tuser: calibrated
//  cfg       in         cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
//  Sequence: a velocity item makes three passes through the 23-step shift-add
//  multiplier and one through the 55-step restoring divider before its result
//  is handed on; the next item is accepted only after that.
//  A calibration item goes straight to the output; the one that completes
//  calibration runs the divider once for the mean.
//  Reset: asynchronous, active low; clears the offset, velocity, last timestamp
//  and calibration count, and loads the register defaults. No clearing pass.
//  Stalls: the result waits in an output register while the next item is
//  accepted; that item's result holds in its last state until the register
//  frees up.
// -----------------------------------------------------------------------------
module accel_velocity_integrator_core
  import accel_vi_pkg::*;
#(
  parameter int unsigned CAL_SAMPLES = CAL_SAMPLES_DEF  // 1 .. 511
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,   // raw_accel[15:0], timestamp_ms[47:16]
  input  logic                 s_axis_tuser,   // req_type

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,   // velocity_q16[31:0]
  output logic                 m_axis_tuser,   // calibrated

  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CAL_FULL = CNT_W'(CAL_SAMPLES);
  localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES - 1);
  localparam logic [DEN_W-1:0] CAL_DEN  = DEN_W'(CAL_SAMPLES);
  // remainder at or above this rounds the mean up (ties away from zero)
  localparam logic [DEN_W-1:0] CAL_HALF = DEN_W'(CAL_SAMPLES - CAL_SAMPLES / 2);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_LOAD,   // take |raw*2^9 - offset| into the multiplier
    ST_A_MUL,    // times 9.81
    ST_A_DONE,   // round, deadband, load a * dt
    ST_D_MUL,
    ST_D_DONE,   // load product into the divider
    ST_D_DIV,    // divide by 1000
    ST_Q_ROUND,  // round and clamp the increment
    ST_V_ADD,    // add to velocity, saturate
    ST_E_LOAD,   // load |v| * decay
    ST_E_MUL,
    ST_E_DONE,   // round, deadband
    ST_V_FIN,    // restore sign into velocity
    ST_C_LOAD,   // load |offset_sum| * 2^9 into the divider
    ST_C_DIV,    // divide by the sample count
    ST_C_FIN,    // round, store offset
    ST_EMIT      // hand the result to the output register
  } state_e;

  // Control and architectural state
  state_e             state_q, state_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [VEL_W-1:0]   out_vel_q, out_vel_d;
  logic               out_cal_q, out_cal_d;
  logic [CFG_W-1:0]   accel_db_q, accel_db_d;
  logic [CFG_W-1:0]   vel_db_q, vel_db_d;
  logic [CFG_W-1:0]   decay_q, decay_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   cal_count_q, cal_count_d;
  logic [OFS_W-1:0]   offset_q, offset_d;
  logic [TS_W-1:0]    last_time_q, last_time_d;
  logic [VEL_W-1:0]   velocity_q, velocity_d;

  // Working registers
  logic [DIFF_W-1:0]  diff_q, diff_d;
  logic [TS_W-1:0]    dt_q, dt_d;
  logic               neg_q, neg_d;
  logic [MA_W-1:0]    ma_q, ma_d;
  logic [MA_W-1:0]    mh_q, mh_d;
  logic [ML_W-1:0]    ml_q, ml_d;
  logic [DQ_W-1:0]    dq_q, dq_d;
  logic [DEN_W-1:0]   rem_q, rem_d;
  logic [QC_W-1:0]    qc_q, qc_d;
  logic [VEL_W-1:0]   vsum_q, vsum_d;
  logic [VEL_W-1:0]   vmag_q, vmag_d;

  // Datapath
  logic [ACC_W-1:0]   raw;
  logic [TS_W-1:0]    now;
  logic [MA_W:0]      mul_sum;
  logic [PROD_W-1:0]  prod;
  logic [DEN_W-1:0]   div_den;
  logic [DEN_W:0]     div_trial;
  logic [DEN_W:0]     div_diff;
  logic               div_ge;
  logic [DIFF_W-1:0]  diff_abs;
  logic [MA_W-1:0]    a_round;
  logic               a_keep;
  logic [QC_W-1:0]    q_round;
  logic [VSUM_W-1:0]  v_ext;
  logic [VSUM_W-1:0]  qc_ext;
  logic [VSUM_W-1:0]  v_sum;
  logic               v_in_range;
  logic [VEL_W-1:0]   e_round;
  logic [SUM_W-1:0]   c_abs;
  logic [OFS_W-1:0]   c_round;
  logic               out_free;

  assign raw = s_axis_tdata[ACC_W-1:0];
  assign now = s_axis_tdata[ACC_W +: TS_W];

  // One shift-add step: add multiplicand on the multiplier's low bit, shift right
  assign mul_sum = {1'b0, mh_q} + (ml_q[0] ? {1'b0, ma_q} : '0);
  assign prod    = {mh_q, ml_q};

  // One restoring-division step: bring in the next dividend bit
  assign div_den   = (state_q == ST_C_DIV) ? CAL_DEN : DT_DIV;
  assign div_trial = {rem_q, dq_q[DQ_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_den};
  assign div_diff  = div_trial - {1'b0, div_den};

  assign diff_abs = diff_q[DIFF_W-1] ? (~diff_q + DIFF_W'(1)) : diff_q;

  // Acceleration: round at 2^23, zero inside the deadband
  assign a_round = prod[G_SHIFT +: MA_W] + MA_W'(prod[G_SHIFT-1]);
  assign a_keep  = a_round >= MA_W'(accel_db_q);

  // Increment a*dt/1000: round from the remainder, clamp far beyond the 32-bit range
  assign q_round = {1'b0, dq_q[QC_W-2:0]} + QC_W'(rem_q >= DT_HALF);

  assign v_ext      = {{(VSUM_W-VEL_W){velocity_q[VEL_W-1]}}, velocity_q};
  assign qc_ext     = VSUM_W'(qc_q);
  assign v_sum      = neg_q ? (v_ext - qc_ext) : (v_ext + qc_ext);
  assign v_in_range = (&v_sum[VSUM_W-1:VEL_W-1]) || (~|v_sum[VSUM_W-1:VEL_W-1]);

  // Decay: round at 2^16
  assign e_round = prod[D_SHIFT +: VEL_W] + VEL_W'(prod[D_SHIFT-1]);

  assign c_abs   = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
  assign c_round = dq_q[OFS_W-1:0] + OFS_W'(rem_q >= CAL_HALF);

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_vel_d   = out_vel_q;
    out_cal_d   = out_cal_q;
    accel_db_d  = accel_db_q;
    vel_db_d    = vel_db_q;
    decay_d     = decay_q;
    sum_d       = sum_q;
    cal_count_d = cal_count_q;
    offset_d    = offset_q;
    last_time_d = last_time_q;
    velocity_d  = velocity_q;
    diff_d      = diff_q;
    dt_d        = dt_q;
    neg_d       = neg_q;
    ma_d        = ma_q;
    mh_d        = mh_q;
    ml_d        = ml_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    qc_d        = qc_q;
    vsum_d      = vsum_q;
    vmag_d      = vmag_q;

    // Configuration writes; unknown indexes drop
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACCEL_DB: accel_db_d = cfg_wdata_i;
        REG_VEL_DB:   vel_db_d   = cfg_wdata_i;
        REG_DECAY:    decay_d    = cfg_wdata_i;
        default: ;
      endcase
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            dt_d        = now - last_time_q;
            last_time_d = now;
            diff_d      = {raw[ACC_W-1], raw, {OFS_FRAC{1'b0}}}
                          - {offset_q[OFS_W-1], offset_q};
            state_d     = ST_A_LOAD;
          end else if (cal_count_q != CAL_FULL) begin
            sum_d       = sum_q + {{(SUM_W-ACC_W){raw[ACC_W-1]}}, raw};
            cal_count_d = cal_count_q + CNT_W'(1);
            state_d     = (cal_count_q == CAL_LAST) ? ST_C_LOAD : ST_EMIT;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end

      ST_A_LOAD: begin
        neg_d   = diff_q[DIFF_W-1];
        ma_d    = MA_W'(diff_abs);
        mh_d    = '0;
        ml_d    = GRAVITY_Q16;
        cnt_d   = MUL_LAST;
        state_d = ST_A_MUL;
      end

      ST_A_MUL, ST_D_MUL, ST_E_MUL: begin
        mh_d  = mul_sum[MA_W:1];
        ml_d  = {mul_sum[0], ml_q[ML_W-1:1]};
        cnt_d = cnt_q - STEP_W'(1);
        if (cnt_q == '0) begin
          case (state_q)
            ST_A_MUL: state_d = ST_A_DONE;
            ST_D_MUL: state_d = ST_D_DONE;
            default:  state_d = ST_E_DONE;
          endcase
        end
      end

      ST_A_DONE: begin
        ma_d    = dt_q;
        mh_d    = '0;
        ml_d    = a_keep ? a_round[ML_W-1:0] : '0;
        cnt_d   = MUL_LAST;
        state_d = ST_D_MUL;
      end

      ST_D_DONE: begin
        dq_d    = prod;
        rem_d   = '0;
        cnt_d   = DIV_LAST;
        state_d = ST_D_DIV;
      end

      ST_D_DIV, ST_C_DIV: begin
        rem_d = div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
        dq_d  = {dq_q[DQ_W-2:0], div_ge};
        cnt_d = cnt_q - STEP_W'(1);
        if (cnt_q == '0) begin
          state_d = (state_q == ST_C_DIV) ? ST_C_FIN : ST_Q_ROUND;
        end
      end

      ST_Q_ROUND: begin
        qc_d    = (|dq_q[DQ_W-1:QC_W-1]) ? QC_LIMIT : q_round;
        state_d = ST_V_ADD;
      end

      ST_V_ADD: begin
        if (v_in_range) begin
          vsum_d = v_sum[VEL_W-1:0];
        end else begin
          vsum_d = v_sum[VSUM_W-1] ? VEL_MIN : VEL_MAX;
        end
        state_d = ST_E_LOAD;
      end

      ST_E_LOAD: begin
        neg_d   = vsum_q[VEL_W-1];
        ma_d    = vsum_q[VEL_W-1] ? (~vsum_q + VEL_W'(1)) : vsum_q;
        mh_d    = '0;
        ml_d    = ML_W'(decay_q);
        cnt_d   = MUL_LAST;
        state_d = ST_E_MUL;
      end

      ST_E_DONE: begin
        vmag_d  = (e_round < VEL_W'(vel_db_q)) ? '0 : e_round;
        state_d = ST_V_FIN;
      end

      ST_V_FIN: begin
        velocity_d = neg_q ? (~vmag_q + VEL_W'(1)) : vmag_q;
        state_d    = ST_EMIT;
      end

      ST_C_LOAD: begin
        neg_d   = sum_q[SUM_W-1];
        dq_d    = DQ_W'({c_abs, {OFS_FRAC{1'b0}}});
        rem_d   = '0;
        cnt_d   = DIV_LAST;
        state_d = ST_C_DIV;
      end

      ST_C_FIN: begin
        offset_d = neg_q ? (~c_round + OFS_W'(1)) : c_round;
        state_d  = ST_EMIT;
      end

      ST_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_vel_d   = velocity_q;
          out_cal_d   = (cal_count_q == CAL_FULL);
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_vel_q   <= '0;
      out_cal_q   <= 1'b0;
      accel_db_q  <= ACCEL_DB_RST;
      vel_db_q    <= VEL_DB_RST;
      decay_q     <= DECAY_RST;
      sum_q       <= '0;
      cal_count_q <= '0;
      offset_q    <= '0;
      last_time_q <= '0;
      velocity_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_vel_q   <= out_vel_d;
      out_cal_q   <= out_cal_d;
      accel_db_q  <= accel_db_d;
      vel_db_q    <= vel_db_d;
      decay_q     <= decay_d;
      sum_q       <= sum_d;
      cal_count_q <= cal_count_d;
      offset_q    <= offset_d;
      last_time_q <= last_time_d;
      velocity_q  <= velocity_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    dt_q   <= dt_d;
    neg_q  <= neg_d;
    ma_q   <= ma_d;
    mh_q   <= mh_d;
    ml_q   <= ml_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    qc_q   <= qc_d;
    vsum_q <= vsum_d;
    vmag_q <= vmag_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_vel_q;
  assign m_axis_tuser  = out_cal_q;

endmodule

// ----- sv/accel_vi_checker.sv -----
// -----------------------------------------------------------------------------
// Velocity integrator port checker
// Watches the stream ports of the core over time; bound to the core.
// -----------------------------------------------------------------------------
module accel_vi_checker
  import accel_vi_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [OUT_W-1:0]   m_axis_tdata,   // velocity_q16[31:0]
  input logic               m_axis_tuser    // calibrated
);

  logic cal_seen_q;

  // Remember that a calibrated result has been delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_seen_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser) begin
      cal_seen_q <= 1'b1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && cal_seen_q) |-> m_axis_tuser)
    else $error("calibrated flag fell after calibration completed");

endmodule

bind accel_velocity_integrator_core accel_vi_checker u_accel_vi_checker (.*);
